@@ rtl/tssr_pkg.sv @@
// ----------------------------------------------------------------------------
// tssr_pkg
// Shared types and constants for the tile and sprite scanline renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tssr_pkg;

    localparam int VRAM_BYTES       = 16384;
    localparam int VRAM_AW          = 14;
    localparam int SPRITE_ENTRIES   = 64;
    localparam int LINE_PIXELS      = 256;
    localparam int SPRITES_PER_LINE = 8;

    localparam logic [7:0] LIST_END     = 8'd208;
    localparam logic [8:0] SCROLL_WRAP  = 9'd224;
    localparam logic [9:0] Y_WRAP_ABOVE = 10'd240;
    localparam logic [7:0] SHOWN_LINES  = 8'd192;

    typedef enum logic [2:0] {
        CFG_MODE_A      = 3'd0,
        CFG_MODE_B      = 3'd1,
        CFG_NAME_BASE   = 3'd2,
        CFG_SPR_BASE    = 3'd3,
        CFG_SPR_PAT_HI  = 3'd4,
        CFG_SCROLL_X    = 3'd5,
        CFG_SCROLL_Y    = 3'd6,
        CFG_SPR_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BG_SLOT,
        ST_BG_ZERO,
        ST_BG_FETCH,
        ST_BG_PIX,
        ST_SP_YRD,
        ST_SP_YCHK,
        ST_SP_XRD,
        ST_SP_NRD,
        ST_SP_NCAP,
        ST_SP_PL,
        ST_SP_PX,
        ST_SP_PW,
        ST_OUT_RD,
        ST_OUT_WAIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/tile_sprite_scanline_renderer_core.sv @@
// ----------------------------------------------------------------------------
// tile_sprite_scanline_renderer_core
// A render fetches the background tile slot by tile slot, then scans the sprite
// entries, reading the pattern and walking the pixel columns of each sprite on
// the line with an extra write per opaque pixel, then sends the groups out.
// One transaction at a time; the single VRAM read port sets the pace.
// Reset: synchronous; a clearing pass after it zeroes VRAM, not ready meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tile_sprite_scanline_renderer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [13:0] i_vram_address,
    input  wire logic [7:0]  i_vram_data,
    input  wire logic [7:0]  i_line_number,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [39:0]      o_pixel_group,
    output logic [4:0]       o_group_index,
    output logic             o_last_group,
    output logic             o_sprite_collision
);

    // ---------------- config registers ----------------
    logic [7:0] r_mode_a, r_mode_b, r_scroll_x, r_scroll_y;
    logic [2:0] r_name_base;
    logic [5:0] r_spr_base;
    logic       r_spr_pat_hi, r_spr_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_a     <= '0;
            r_mode_b     <= '0;
            r_name_base  <= 3'd7;
            r_spr_base   <= 6'd63;
            r_spr_pat_hi <= 1'b0;
            r_scroll_x   <= '0;
            r_scroll_y   <= '0;
            r_spr_limit  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tssr_pkg::CFG_MODE_A:     r_mode_a     <= i_cfg_data;
                tssr_pkg::CFG_MODE_B:     r_mode_b     <= i_cfg_data;
                tssr_pkg::CFG_NAME_BASE:  r_name_base  <= i_cfg_data[2:0];
                tssr_pkg::CFG_SPR_BASE:   r_spr_base   <= i_cfg_data[5:0];
                tssr_pkg::CFG_SPR_PAT_HI: r_spr_pat_hi <= i_cfg_data[0];
                tssr_pkg::CFG_SCROLL_X:   r_scroll_x   <= i_cfg_data;
                tssr_pkg::CFG_SCROLL_Y:   r_scroll_y   <= i_cfg_data;
                tssr_pkg::CFG_SPR_LIMIT:  r_spr_limit  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- memories ----------------
    logic [7:0] vram_mem [tssr_pkg::VRAM_BYTES];
    logic       vram_we;
    logic [13:0] vram_waddr, vram_raddr;
    logic [7:0] vram_wdata, r_vq;

    always_ff @(posedge i_clk) begin
        if (vram_we) begin
            vram_mem[vram_waddr] <= vram_wdata;
        end
        r_vq <= vram_mem[vram_raddr];
    end

    // line store: bit6 sprite mark, bit5 priority, bit4 palette, bits3:0 pixel
    logic [6:0] ls_mem [tssr_pkg::LINE_PIXELS];
    logic       ls_we;
    logic [7:0] ls_waddr, ls_raddr;
    logic [6:0] ls_wdata, r_lq;

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            ls_mem[ls_waddr] <= ls_wdata;
        end
        r_lq <= ls_mem[ls_raddr];
    end

    // ---------------- sequencer registers ----------------
    tssr_pkg::t_state r_state, n_state;
    logic [13:0] r_clr, n_clr;
    logic [7:0]  r_line, n_line, r_vline, n_vline;
    logic [5:0]  r_slot, n_slot;
    logic [3:0]  r_pix, n_pix;
    logic [2:0]  r_step, n_step;
    logic [12:0] r_attr, n_attr;
    logic [7:0]  r_pl [4];
    logic [7:0]  n_pl [4];
    logic [5:0]  r_spr, n_spr;
    logic [6:0]  r_cnt, n_cnt;
    logic signed [9:0] r_spy, n_spy, r_spx, n_spx;
    logic [8:0]  r_spn, n_spn;
    logic [3:0]  r_x, n_x;
    logic [3:0]  r_sp, n_sp;
    logic [4:0]  r_grp, n_grp;
    logic [39:0] r_word, n_word;
    logic        r_ovalid, n_ovalid, r_coll, n_coll;

    // ---------------- shared decode ----------------
    logic       in_acc, out_acc;
    logic [7:0] hs;
    logic [2:0] shift;
    logic       locked;
    logic [2:0] bg_row, bg_trow, bg_col;
    logic [4:0] bg_rowsel, bg_ntcol;
    logic       bg_last, zero_last, slot_skip;
    logic [7:0] bg_pos;
    logic [3:0] bg_pix4;
    logic       tall, big;
    logic [5:0] hgt;
    logic [9:0] yp0;
    logic signed [10:0] yp11, line11;
    logic       sp_hit, sp_endy, sp_limit, sp_lastent, x_last;
    logic [4:0] sp_row5;
    logic [3:0] sp_row;
    logic [9:0] sp_tile;
    logic signed [10:0] sp_pos;
    logic [2:0] sp_col;
    logic [3:0] sp_pix4;
    logic       sp_draw;
    logic [8:0] vsum;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_ovalid && i_ready;

    assign hs    = (r_mode_a[6] && (r_line < 8'd16)) ? 8'd0 : (8'd0 - r_scroll_x);
    assign shift = hs[2:0];
    assign bg_ntcol = hs[7:3] + r_slot[4:0];
    assign locked   = r_mode_a[7] && (r_slot >= 6'd24);
    assign bg_row   = locked ? r_line[2:0] : r_vline[2:0];
    assign bg_rowsel = locked ? r_line[7:3] : r_vline[7:3];
    assign bg_trow  = r_attr[10] ? ~bg_row : bg_row;
    assign bg_col   = r_attr[9] ? ~r_pix[2:0] : r_pix[2:0];
    assign bg_pix4  = {r_pl[3][~bg_col], r_pl[2][~bg_col], r_pl[1][~bg_col],
                       r_pl[0][~bg_col]};
    assign bg_pos   = {r_slot[4:0], r_pix[2:0]} - {5'd0, shift};
    assign bg_last  = (r_slot == 6'd32) ? (r_pix[2:0] == shift - 3'd1)
                                        : (r_pix[2:0] == 3'd7);
    assign zero_last = (r_pix[2:0] == 3'd7 - shift);
    assign slot_skip = (r_slot == 6'd33) || ((r_slot == 6'd32) && (shift == 3'd0));

    assign vsum = {1'b0, i_line_number} + {1'b0, r_scroll_y};

    assign tall = r_mode_b[1];
    assign big  = r_mode_b[0];
    assign hgt  = 6'd8 << ({1'b0, tall} + {1'b0, big});
    assign yp0  = {2'b0, r_vq} + 10'd1;
    // Y past 240 wraps to just above the top line
    assign yp11 = (yp0 > tssr_pkg::Y_WRAP_ABOVE) ? (11'(yp0) - 11'd256) : 11'(yp0);
    assign line11 = {3'b0, r_line};
    assign sp_hit = (line11 >= yp11) && (line11 < yp11 + $signed({5'd0, hgt}));
    assign sp_endy = (r_vq == tssr_pkg::LIST_END);
    assign sp_limit = r_spr_limit && (r_cnt == 7'(tssr_pkg::SPRITES_PER_LINE));
    assign sp_lastent = (r_spr == 6'(tssr_pkg::SPRITE_ENTRIES - 1));
    assign x_last = (r_x == (big ? 4'd15 : 4'd7));

    assign sp_row5 = 5'({2'b0, r_line} - r_spy);
    assign sp_row  = big ? sp_row5[4:1] : sp_row5[3:0];
    assign sp_tile = {1'b0, r_spn} + {9'd0, sp_row[3]};
    assign sp_pos  = {r_spx[9], r_spx} + {7'd0, r_x};
    assign sp_col  = big ? r_x[3:1] : r_x[2:0];
    assign sp_pix4 = {r_pl[3][~sp_col], r_pl[2][~sp_col], r_pl[1][~sp_col],
                      r_pl[0][~sp_col]};
    assign sp_draw = !sp_pos[10] && (sp_pos[9:8] == 2'b00) && (sp_pix4 != 4'd0);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tssr_pkg::ST_CLEAR: begin
                if (r_clr == '1) n_state = tssr_pkg::ST_IDLE;
            end
            tssr_pkg::ST_IDLE: begin
                if (in_acc && i_command && (i_line_number < tssr_pkg::SHOWN_LINES)) begin
                    n_state = tssr_pkg::ST_BG_SLOT;
                end
            end
            tssr_pkg::ST_BG_SLOT: begin
                if ((r_slot == 6'd0) && (shift != 3'd0)) n_state = tssr_pkg::ST_BG_ZERO;
                else if (slot_skip)                      n_state = tssr_pkg::ST_SP_YRD;
                else                                     n_state = tssr_pkg::ST_BG_FETCH;
            end
            tssr_pkg::ST_BG_ZERO: begin
                if (zero_last) n_state = tssr_pkg::ST_BG_SLOT;
            end
            tssr_pkg::ST_BG_FETCH: begin
                if (r_step == 3'd7) n_state = tssr_pkg::ST_BG_PIX;
            end
            tssr_pkg::ST_BG_PIX: begin
                if (bg_last) n_state = tssr_pkg::ST_BG_SLOT;
            end
            tssr_pkg::ST_SP_YRD: n_state = tssr_pkg::ST_SP_YCHK;
            tssr_pkg::ST_SP_YCHK: begin
                if (sp_endy)         n_state = tssr_pkg::ST_OUT_RD;
                else if (sp_hit)     n_state = tssr_pkg::ST_SP_XRD;
                else if (sp_lastent) n_state = tssr_pkg::ST_OUT_RD;
                else                 n_state = tssr_pkg::ST_SP_YRD;
            end
            tssr_pkg::ST_SP_XRD: n_state = tssr_pkg::ST_SP_NRD;
            tssr_pkg::ST_SP_NRD: n_state = tssr_pkg::ST_SP_NCAP;
            tssr_pkg::ST_SP_NCAP: begin
                n_state = sp_limit ? tssr_pkg::ST_OUT_RD : tssr_pkg::ST_SP_PL;
            end
            tssr_pkg::ST_SP_PL: begin
                if (r_step == 3'd4) n_state = tssr_pkg::ST_SP_PX;
            end
            tssr_pkg::ST_SP_PX: begin
                if (sp_draw)     n_state = tssr_pkg::ST_SP_PW;
                else if (x_last) n_state = sp_lastent ? tssr_pkg::ST_OUT_RD
                                                      : tssr_pkg::ST_SP_YRD;
            end
            tssr_pkg::ST_SP_PW: begin
                if (x_last) n_state = sp_lastent ? tssr_pkg::ST_OUT_RD
                                                 : tssr_pkg::ST_SP_YRD;
                else        n_state = tssr_pkg::ST_SP_PX;
            end
            tssr_pkg::ST_OUT_RD: begin
                if (r_pix == 4'd8) n_state = tssr_pkg::ST_OUT_WAIT;
            end
            tssr_pkg::ST_OUT_WAIT: begin
                if (out_acc) n_state = (r_grp == 5'd31) ? tssr_pkg::ST_IDLE
                                                        : tssr_pkg::ST_OUT_RD;
            end
            default: n_state = tssr_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and memory ports ----------------
    always_comb begin
        n_clr = r_clr;   n_line = r_line; n_vline = r_vline; n_slot = r_slot;
        n_pix = r_pix;   n_step = r_step; n_attr = r_attr;   n_pl = r_pl;
        n_spr = r_spr;   n_cnt = r_cnt;   n_spy = r_spy;     n_spx = r_spx;
        n_spn = r_spn;   n_x = r_x;       n_sp = r_sp;       n_grp = r_grp;
        n_word = r_word; n_ovalid = r_ovalid; n_coll = r_coll;
        vram_we = 1'b0;  vram_waddr = i_vram_address; vram_wdata = i_vram_data;
        vram_raddr = '0;
        ls_we = 1'b0;    ls_waddr = '0; ls_wdata = '0; ls_raddr = '0;

        case (r_state)
            tssr_pkg::ST_CLEAR: begin
                vram_we    = 1'b1;
                vram_waddr = r_clr;
                vram_wdata = '0;
                n_clr      = r_clr + 14'd1;
            end
            tssr_pkg::ST_IDLE: begin
                vram_we = in_acc && !i_command;
                n_line  = i_line_number;
                n_vline = (vsum >= tssr_pkg::SCROLL_WRAP) ? 8'(vsum - tssr_pkg::SCROLL_WRAP)
                                                          : vsum[7:0];
                n_slot = '0;
                n_spr  = '0;
                n_cnt  = '0;
                n_grp  = '0;
                n_coll = 1'b0;
            end
            tssr_pkg::ST_BG_ZERO: begin
                ls_we    = 1'b1;
                ls_waddr = {5'd0, r_pix[2:0]};
                n_pix    = r_pix + 4'd1;
                if (zero_last) n_slot = 6'd1;
            end
            tssr_pkg::ST_BG_FETCH: begin
                // steps: 0 name lo, 1 name hi, 3..6 bitplanes; read data lands in the next cycle
                if (r_step <= 3'd1) begin
                    vram_raddr = {r_name_base, bg_rowsel, bg_ntcol, r_step[0]};
                end else begin
                    vram_raddr = {r_attr[8:0], bg_trow, 2'(r_step - 3'd3)};
                end
                if (r_step == 3'd1) n_attr[7:0]  = r_vq;
                if (r_step == 3'd2) n_attr[12:8] = r_vq[4:0];
                if (r_step >= 3'd4) n_pl[2'(r_step - 3'd4)] = r_vq;
                n_step = r_step + 3'd1;
            end
            tssr_pkg::ST_BG_PIX: begin
                ls_we    = 1'b1;
                ls_waddr = bg_pos;
                ls_wdata = {1'b0, r_attr[12], r_attr[11], bg_pix4};
                n_pix    = r_pix + 4'd1;
                if (bg_last) n_slot = r_slot + 6'd1;
            end
            tssr_pkg::ST_SP_YRD: begin
                vram_raddr = {r_spr_base, 2'b00, r_spr};
            end
            tssr_pkg::ST_SP_YCHK: begin
                n_spy = yp11[9:0];
                if (!sp_endy && !sp_hit) n_spr = r_spr + 6'd1;
            end
            tssr_pkg::ST_SP_XRD: begin
                vram_raddr = {r_spr_base, 1'b1, r_spr, 1'b0};
            end
            tssr_pkg::ST_SP_NRD: begin
                vram_raddr = {r_spr_base, 1'b1, r_spr, 1'b1};
                n_spx = {2'b00, r_vq} - (r_mode_a[3] ? 10'sd8 : 10'sd0);
            end
            tssr_pkg::ST_SP_NCAP: begin
                n_spn = {r_spr_pat_hi, r_vq};
                if (tall) n_spn[0] = 1'b0;
                n_cnt = r_cnt + 7'd1;
            end
            tssr_pkg::ST_SP_PL: begin
                vram_raddr = {sp_tile[8:0], sp_row[2:0], r_step[1:0]};
                if (r_step >= 3'd1) n_pl[2'(r_step - 3'd1)] = r_vq;
                n_step = r_step + 3'd1;
                n_x    = '0;
            end
            tssr_pkg::ST_SP_PX: begin
                ls_raddr = sp_pos[7:0];
                n_sp     = sp_pix4;
                if (!sp_draw) begin
                    n_x = r_x + 4'd1;
                    if (x_last) n_spr = r_spr + 6'd1;
                end
            end
            tssr_pkg::ST_SP_PW: begin
                // earlier sprite wins; high-priority opaque background also wins
                if (r_lq[6]) begin
                    n_coll = 1'b1;
                end else if (!(r_lq[5] && (r_lq[3:0] != 4'd0))) begin
                    ls_we = 1'b1;
                end
                ls_waddr = sp_pos[7:0];
                ls_wdata = {3'b101, r_sp};
                n_x = r_x + 4'd1;
                if (x_last) n_spr = r_spr + 6'd1;
            end
            tssr_pkg::ST_OUT_RD: begin
                ls_raddr = {r_grp, r_pix[2:0]};
                if (r_pix != 4'd0) n_word[5 * 3'(r_pix - 4'd1) +: 5] = r_lq[4:0];
                n_pix = r_pix + 4'd1;
                if (r_pix == 4'd8) n_ovalid = 1'b1;
            end
            tssr_pkg::ST_OUT_WAIT: begin
                if (out_acc) begin
                    n_ovalid = 1'b0;
                    n_grp    = r_grp + 5'd1;
                end
            end
            default: ;
        endcase

        // counters restart on every state change
        if (n_state != r_state) begin
            n_pix  = '0;
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tssr_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_coll   <= 1'b0;
            r_pix    <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_coll   <= n_coll;
            r_pix    <= n_pix;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line  <= n_line;
        r_vline <= n_vline;
        r_slot  <= n_slot;
        r_attr  <= n_attr;
        r_pl    <= n_pl;
        r_spr   <= n_spr;
        r_cnt   <= n_cnt;
        r_spy   <= n_spy;
        r_spx   <= n_spx;
        r_spn   <= n_spn;
        r_x     <= n_x;
        r_sp    <= n_sp;
        r_grp   <= n_grp;
        r_word  <= n_word;
    end

    assign o_ready            = (r_state == tssr_pkg::ST_IDLE);
    assign o_valid            = r_ovalid;
    assign o_pixel_group      = r_word;
    assign o_group_index      = r_grp;
    assign o_last_group       = (r_grp == 5'd31);
    assign o_sprite_collision = r_coll;

endmodule

`default_nettype wire

@@ tb/sv/scanline_checker.sv @@
// ----------------------------------------------------------------------------
// scanline_checker
// Watches the command, result and register ports of the scanline renderer.
// Keeps its own copy of video memory and registers, renders every accepted
// shown line itself and compares each result group field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scanline_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic        i_command,
    input  wire logic [13:0] i_vram_address,
    input  wire logic [7:0]  i_vram_data,
    input  wire logic [7:0]  i_line_number,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [39:0] i_pixel_group,
    input  wire logic [4:0]  i_group_index,
    input  wire logic        i_last_group,
    input  wire logic        i_sprite_collision,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_groups_checked
);

    typedef struct packed {
        logic [39:0] pixels;
        logic [4:0]  index;
        logic        last;
        logic        coll;
    } t_group;

    localparam int ADDR_MASK = tssr_pkg::VRAM_BYTES - 1;

    logic [7:0] vram_copy [0:tssr_pkg::VRAM_BYTES-1];
    logic [6:0] line_px   [0:tssr_pkg::LINE_PIXELS-1];
    logic       collided;
    t_group     group_q [$];

    logic [7:0] mode_a, mode_b, scroll_x, scroll_y;
    logic [2:0] name_base;
    logic [5:0] spr_base;
    logic       pat_hi, limit_on;

    assign o_pending = group_q.size();

    function automatic logic [3:0] tile_px(int tile, int row, int col);
        int         a;
        int         s;
        logic [3:0] c;
        a = (tile << 5) + (row << 2);
        s = 7 - (col & 7);
        for (int p = 0; p < 4; p++)
            c[p] = vram_copy[(a + p) & ADDR_MASK][s];
        return c;
    endfunction

    function automatic logic [6:0] tile_bg_px(int attr, int row, int col);
        if (attr & 'h200) col = 7 - col;
        if (attr & 'h400) row = 7 - row;
        return {1'b0, attr[12], attr[11], tile_px(attr & 'h1FF, row & 7, col)};
    endfunction

    function automatic int name_word(int base, int col);
        int a;
        a = base + ((col & 31) << 1);
        return int'(vram_copy[a & ADDR_MASK]) | (int'(vram_copy[(a + 1) & ADDR_MASK]) << 8);
    endfunction

    function automatic void paint_background(int ln);
        int vline, row, hs, ntcol, shift, base, col, attr;
        bit locked;
        vline  = (ln + int'(scroll_y)) % 224;
        row    = vline & 7;
        hs     = (mode_a[6] && ln < 16) ? 0 : 256 - int'(scroll_x);
        ntcol  = (hs >> 3) & 31;
        shift  = hs & 7;
        base   = (int'(name_base) << 11) + ((vline >> 3) << 6);
        locked = 1'b0;
        col    = 0;
        if (shift != 0) begin
            for (int i = 0; i < 8 - shift; i++) line_px[i] = '0;
            col = 1;
        end
        while (col < 32) begin
            // right-column lock: rows follow the raw line, not the scroll
            if (mode_a[7] && !locked && col >= 24) begin
                locked = 1'b1;
                row    = ln & 7;
                base   = (int'(name_base) << 11) + ((ln >> 3) << 6);
            end
            attr = name_word(base, col + ntcol);
            for (int i = 0; i < 8; i++)
                line_px[(col * 8 + i - shift) & 255] = tile_bg_px(attr, row, i);
            col++;
        end
        if (shift != 0) begin
            attr = name_word(base, 32 + ntcol);
            for (int i = 0; i < shift; i++)
                line_px[(256 - shift + i) & 255] = tile_bg_px(attr, row, i);
        end
    endfunction

    function automatic void paint_sprites(int ln);
        int st, width, height, count, yp, xp, start, stop, row, col, n, pos;
        bit tall, big;
        logic [3:0] sp;
        logic [6:0] under;
        st     = int'(spr_base) << 8;
        tall   = mode_b[1];
        big    = mode_b[0];
        width  = big ? 16 : 8;
        height = (tall ? 16 : 8) * (big ? 2 : 1);
        count  = 0;
        for (int i = 0; i < tssr_pkg::SPRITE_ENTRIES; i++) begin
            yp = vram_copy[(st + i) & ADDR_MASK];
            if (yp == int'(tssr_pkg::LIST_END)) return;
            yp += 1;
            if (yp > 240) yp -= 256;
            if (ln < yp || ln >= yp + height) continue;
            xp = vram_copy[(st + 'h80 + 2 * i) & ADDR_MASK];
            n  = vram_copy[(st + 'h81 + 2 * i) & ADDR_MASK];
            count++;
            if (limit_on && count == tssr_pkg::SPRITES_PER_LINE + 1) return;
            if (mode_a[3]) xp -= 8;
            if (pat_hi) n |= 'h100;
            if (tall) n &= 'h1FE;
            start = (xp < 0) ? -xp : 0;
            stop  = (xp + width > tssr_pkg::LINE_PIXELS) ? tssr_pkg::LINE_PIXELS - xp
                                                         : width;
            row   = ln - yp;
            if (big) row = row >> 1;
            for (int x = start; x < stop; x++) begin
                col = big ? (x >> 1) : x;
                sp  = tile_px(n + (row >> 3), row & 7, col);
                if (sp == 0) continue;
                pos   = (xp + x) & 255;
                under = line_px[pos];
                // earlier sprite wins; high-priority opaque background wins too
                if (under[6])
                    collided = 1'b1;
                else if (!(under[5] && under[3:0] != 0))
                    line_px[pos] = {2'b10, 1'b1, sp};
            end
        end
    endfunction

    function automatic void predict_line(int ln);
        t_group g;
        if (ln >= int'(tssr_pkg::SHOWN_LINES)) return;
        collided = 1'b0;
        paint_background(ln);
        paint_sprites(ln);
        for (int k = 0; k < 32; k++) begin
            g.pixels = '0;
            for (int p = 0; p < 8; p++)
                g.pixels |= 40'(line_px[k * 8 + p][4:0]) << (5 * p);
            g.index = 5'(k);
            g.last  = (k == 31);
            g.coll  = collided;
            group_q.push_back(g);
        end
    endfunction

    always @(posedge i_clk) begin
        t_group want;
        int     errs;
        if (!i_rst_n) begin
            for (int a = 0; a < tssr_pkg::VRAM_BYTES; a++) vram_copy[a] <= '0;
            collided         <= 1'b0;
            mode_a           <= 8'd0;
            mode_b           <= 8'd0;
            name_base        <= 3'd7;
            spr_base         <= 6'd63;
            pat_hi           <= 1'b0;
            scroll_x         <= 8'd0;
            scroll_y         <= 8'd0;
            limit_on         <= 1'b1;
            o_fail_count     <= 0;
            o_groups_checked <= 0;
            group_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (tssr_pkg::t_cfg_idx'(i_cfg_index))
                    tssr_pkg::CFG_MODE_A:     mode_a    = i_cfg_data;
                    tssr_pkg::CFG_MODE_B:     mode_b    = i_cfg_data;
                    tssr_pkg::CFG_NAME_BASE:  name_base = i_cfg_data[2:0];
                    tssr_pkg::CFG_SPR_BASE:   spr_base  = i_cfg_data[5:0];
                    tssr_pkg::CFG_SPR_PAT_HI: pat_hi    = i_cfg_data[0];
                    tssr_pkg::CFG_SCROLL_X:   scroll_x  = i_cfg_data;
                    tssr_pkg::CFG_SCROLL_Y:   scroll_y  = i_cfg_data;
                    tssr_pkg::CFG_SPR_LIMIT:  limit_on  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                errs = 0;
                o_groups_checked <= o_groups_checked + 1;
                if (group_q.size() == 0) begin
                    $display("%0t: group %0d arrived with nothing pending",
                             $time, i_group_index);
                    errs++;
                end else begin
                    want = group_q.pop_front();
                    if (want.pixels !== i_pixel_group) begin
                        $display("%0t: pixel_group exp %h got %h (group %0d)",
                                 $time, want.pixels, i_pixel_group, want.index);
                        errs++;
                    end
                    if (want.index !== i_group_index) begin
                        $display("%0t: group_index exp %0d got %0d",
                                 $time, want.index, i_group_index);
                        errs++;
                    end
                    if (want.last !== i_last_group) begin
                        $display("%0t: last_group exp %0b got %0b",
                                 $time, want.last, i_last_group);
                        errs++;
                    end
                    if (want.coll !== i_sprite_collision) begin
                        $display("%0t: sprite_collision exp %0b got %0b",
                                 $time, want.coll, i_sprite_collision);
                        errs++;
                    end
                end
                if (errs != 0) o_fail_count <= o_fail_count + errs;
            end
            // predict after the compare so the queue order stays right
            if (i_valid && i_ready_in) begin
                if (i_command)
                    predict_line(int'(i_line_number));
                else
                    vram_copy[i_vram_address] = i_vram_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the tile and sprite scanline renderer.
// Fills video memory with tiles, name entries and sprite attributes, renders
// lines under several register settings (defaults, extremes, random) and
// lets scanline_checker predict and compare every result group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    // a render with every sprite on the line and a long result stall stays
    // far below this; so does the reset clearing pass
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLDOFF_CYCLES = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [13:0] i_vram_address = '0;
    logic [7:0]  i_vram_data = '0;
    logic [7:0]  i_line_number = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [39:0] o_pixel_group;
    logic [4:0]  o_group_index;
    logic        o_last_group;
    logic        o_sprite_collision;

    int fail_count, pending, groups_checked;
    int renders_sent = 0, writes_sent = 0, idle_cycles = 0;
    bit calm = 1'b0;      // no idling on either side while set
    bit held = 1'b0;

    // current table bases, used only to aim random writes
    logic [2:0] cur_name = 3'd7;
    logic [5:0] cur_spr  = 6'd63;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tile_sprite_scanline_renderer_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_vram_address(i_vram_address), .i_vram_data(i_vram_data),
        .i_line_number(i_line_number),
        .o_valid(o_valid), .i_ready(i_ready), .o_pixel_group(o_pixel_group),
        .o_group_index(o_group_index), .o_last_group(o_last_group),
        .o_sprite_collision(o_sprite_collision)
    );

    scanline_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_command(i_command),
        .i_vram_address(i_vram_address), .i_vram_data(i_vram_data),
        .i_line_number(i_line_number),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_pixel_group(o_pixel_group),
        .i_group_index(o_group_index), .i_last_group(o_last_group),
        .i_sprite_collision(o_sprite_collision),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_groups_checked(groups_checked)
    );

    // one transaction on the command channel; valid holds until accepted
    task automatic send_item(input logic cmd, input logic [13:0] addr,
                             input logic [7:0] data, input logic [7:0] ln);
        if (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_vram_address <= addr;
        i_vram_data    <= data;
        i_line_number  <= ln;
        do @(posedge i_clk); while (!o_ready);
        if (cmd) renders_sent++;
        else     writes_sent++;
    endtask

    task automatic vram_write(input int addr, input int data);
        send_item(1'b0, 14'(addr), 8'(data), 8'($urandom));
    endtask

    task automatic render(input int ln);
        send_item(1'b1, 14'($urandom), 8'($urandom), 8'(ln));
    endtask

    // drain: all results in, then a margin for items that return nothing
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] a, input logic [7:0] b,
                              input logic [2:0] nb, input logic [5:0] sb,
                              input logic ph, input logic [7:0] sx,
                              input logic [7:0] sy, input logic lim);
        logic [7:0] vals [8];
        vals = '{a, b, 8'(nb), 8'(sb), 8'(ph), sx, sy, 8'(lim)};
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_name = nb;
        cur_spr  = sb;
    endtask

    // random items, weighted toward the tables a line actually reads
    task automatic random_items(input int count);
        int r, st, nt;
        st = int'(cur_spr) << 8;
        nt = int'(cur_name) << 11;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 22) begin
                if ($urandom_range(99) < 85) render($urandom_range(0, 191));
                else                         render($urandom_range(192, 255));
            end else if (r < 40) begin
                // sprite Y: mostly on visible lines, some terminators and wraps
                if ($urandom_range(9) == 0)
                    vram_write(st + $urandom_range(0, 63), tssr_pkg::LIST_END);
                else if ($urandom_range(9) == 0)
                    vram_write(st + $urandom_range(0, 63), $urandom_range(240, 255));
                else
                    vram_write(st + $urandom_range(0, 63), $urandom_range(0, 200));
            end else if (r < 55) begin
                vram_write(st + 'h80 + $urandom_range(0, 127), $urandom_range(0, 255));
            end else if (r < 65) begin
                vram_write($urandom_range(0, 127), $urandom_range(0, 255));
            end else if (r < 75) begin
                vram_write('h2000 + $urandom_range(0, 127), $urandom_range(0, 255));
            end else if (r < 88) begin
                vram_write(nt + $urandom_range(0, 'h7FF), $urandom_range(0, 255));
            end else begin
                vram_write($urandom_range(0, 16383), $urandom_range(0, 255));
            end
        end
    endtask

    // result side: random stalls, one long hold-off once traffic is flowing
    initial begin
        forever begin
            @(posedge i_clk);
            if (!held && groups_checked >= 40) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            i_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // watchdog: cycles in which no transaction of either channel completes
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults written back explicitly
        write_regs(8'h00, 8'h00, 3'd7, 6'd63, 1'b0, 8'h00, 8'h00, 1'b1);

        // directed: tile 0 rows, a flipped name entry, sprites at the edges
        vram_write('h0000, 'hFF);
        vram_write('h0001, 'h00);
        vram_write('h0002, 'hAA);
        vram_write('h0003, 'h55);
        vram_write('h0004, 'h0F);
        vram_write('h3800, 'h01);
        vram_write('h3801, 'h1E);          // flips, palette and priority bits
        vram_write('h3F00, 'd4);
        vram_write('h3F80, 'd250);         // runs off the right edge
        vram_write('h3F81, 'd0);
        vram_write('h3F01, 'd4);
        vram_write('h3F82, 'd252);         // overlaps the first sprite
        vram_write('h3F02, tssr_pkg::LIST_END);
        vram_write('h3FFF, 'hFF);
        render(5);
        render(0);
        render(191);
        render(192);
        render(255);
        random_items(40);

        // extremes, with no idling anywhere
        wait_drained();
        calm = 1'b1;
        write_regs(8'hFF, 8'h03, 3'd7, 6'd63, 1'b1, 8'hFF, 8'hFF, 1'b0);
        random_items(55);
        calm = 1'b0;

        wait_drained();
        write_regs(8'h00, 8'h00, 3'd0, 6'd0, 1'b0, 8'h00, 8'h00, 1'b0);
        random_items(45);

        wait_drained();
        write_regs(8'($urandom), 8'($urandom), 3'($urandom), 6'($urandom),
                   1'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        random_items(30);
        // sender stops until every pending group is back
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        random_items(30);

        wait_drained();
        write_regs(8'($urandom) | 8'h48, 8'h02, 3'($urandom), 6'($urandom),
                   1'($urandom), 8'($urandom_range(1, 7)), 8'($urandom_range(200, 255)),
                   1'($urandom));
        random_items(50);

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d line renders, %0d memory writes, %0d groups compared",
                 renders_sent, writes_sent, groups_checked);
        $display("settings: reset values, all-max, all-zero and two random sets");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
